@@ hdl/sobel_pkg.sv @@
// ----------------------------------------------------------------------------
// sobel_pkg: shared types and constants
// Pixel, gradient and magnitude types used by the Sobel edge block.
// ----------------------------------------------------------------------------
package sobel_pkg;

	localparam int CH_W  = 8;
	localparam int POS_W = 11;
	localparam int CFG_W = 12;

	typedef logic [3*CH_W-1:0] pix_t;     // red in [23:16], green [15:8], blue [7:0]
	typedef logic signed [10:0] grad_t;   // -1020..1020
	typedef logic [9:0] agrad_t;          // |grad|
	typedef logic [CH_W-1:0] mag_t;

	localparam mag_t        MAG_CAP  = 8'd255;
	// sums above this round to 256 or more
	localparam logic [20:0] SQ_LIMIT = 21'd65280;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	function automatic agrad_t abs_grad(input grad_t g);
		grad_t n;
		n = -g;
		return g[10] ? agrad_t'(n) : agrad_t'(g);
	endfunction

endpackage

@@ hdl/sobel_ifs.sv @@
// ----------------------------------------------------------------------------
// sobel_ifs: request channels of the Sobel edge block
// Pixel/drain request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sobel_pix_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;

	modport source (output valid, command, red_in, green_in, blue_in, input ready);
	modport sink   (input valid, command, red_in, green_in, blue_in, output ready);
endinterface

interface sobel_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  red_out;
	logic [7:0]  green_out;
	logic [7:0]  blue_out;
	logic [10:0] out_row;
	logic [10:0] out_col;
	logic        last_of_frame;

	modport source (output valid, red_out, green_out, blue_out, out_row, out_col,
		last_of_frame, input ready);
	modport sink   (input valid, red_out, green_out, blue_out, out_row, out_col,
		last_of_frame, output ready);
endinterface

@@ hdl/sobel_edge_magnitude_rgb.sv @@
// Results: a pixel yields up to two results, the second (last column) only once the
// first is taken; a drain yields one.
// Throughput: one request at a time; the next is accepted once all results of the
// current one are taken. Each result passes through the bit-serial root units.
// Reset: counters, window and drain state clear; line stores keep garbage until written.
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb: streaming 3x3 Sobel edge magnitude, RGB
// Two line stores in synchronous RAM plus a 3x3 window; per-channel magnitude
// by three shared-timing square-root units.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [11:0]       cfg_data,
	sobel_pix_if.sink         pixel,
	sobel_res_if.source       result
);

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 1);
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;   // waiting for a request
	localparam logic [2:0] S_PXRD = 3'd1;   // line data back, shift window, write back
	localparam logic [2:0] S_DRA  = 3'd2;   // drain: read one column
	localparam logic [2:0] S_DRB  = 3'd3;   // drain: shift column into window
	localparam logic [2:0] S_JOB  = 3'd4;   // gradients into root units
	localparam logic [2:0] S_MAG  = 3'd5;   // wait for roots
	localparam logic [2:0] S_OUT  = 3'd6;   // result held until taken

	// result kinds
	localparam logic [1:0] K_INNER = 2'd0;  // (r-1, c-1) on pixel (r, c)
	localparam logic [1:0] K_LAST  = 2'd1;  // last column of row r-1
	localparam logic [1:0] K_DRAIN = 2'd2;  // final row

	logic [2:0]               state_q;
	logic [11:0]              cfg_w_q, cfg_h_q;
	logic [CW-1:0]            eff_w;
	logic [RW-1:0]            eff_h;
	logic [CW-1:0]            col_q, drain_q, cur_c_q, res_col_q;
	logic [RW-1:0]            row_q, res_row_q;
	logic                     draining_q;
	logic [1:0]               k_q;
	logic                     ok_q;
	sobel_pkg::pix_t          px_q;
	logic [1:0]               kind_q;
	logic                     pend_b_q;
	logic                     res_last_q;
	sobel_pkg::pix_t          win_q [3][3];   // [0] two rows up, column 2 newest

	// line stores
	sobel_pkg::pix_t          older_mem [MAX_WIDTH];
	sobel_pkg::pix_t          newer_mem [MAX_WIDTH];
	sobel_pkg::pix_t          rd_old_q, rd_new_q;
	logic [AW-1:0]            rd_addr, dr_addr;
	logic                     mem_we;

	// drain column walk: d-1, d, d+1
	logic [CW:0]              cc, cc_m1;
	logic                     cc_ok;

	sobel_pkg::pix_t          nb [3][3];
	logic                     top_zero;
	sobel_pkg::grad_t         gx [3], gy [3];
	logic [2:0]               mag_done;
	sobel_pkg::mag_t          mag [3];

	logic                     pix_acc;
	logic [CW:0]              col_nx;
	logic [RW:0]              row_nx;
	logic [CW:0]              drain_nx;

	// size registers: zero acts as one, oversize clamps to the maximum
	always_comb begin
		if (cfg_w_q == 12'd0)                  eff_w = CW'(1);
		else if (32'(cfg_w_q) > 32'(MAX_WIDTH)) eff_w = CW'(MAX_WIDTH);
		else                                   eff_w = CW'(cfg_w_q);
		if (cfg_h_q == 12'd0)                   eff_h = RW'(1);
		else if (32'(cfg_h_q) > 32'(MAX_HEIGHT)) eff_h = RW'(MAX_HEIGHT);
		else                                    eff_h = RW'(cfg_h_q);
	end

	assign cc      = (CW+1)'(drain_q) + (CW+1)'(k_q);
	assign cc_m1   = cc - (CW+1)'(1);
	assign cc_ok   = (cc != '0) && (cc_m1 < (CW+1)'(eff_w));
	assign dr_addr = cc_m1[AW-1:0];
	assign rd_addr = (state_q == S_IDLE) ? col_q[AW-1:0] : dr_addr;
	assign mem_we  = (state_q == S_PXRD);

	assign col_nx   = (CW+1)'(col_q) + (CW+1)'(1);
	assign row_nx   = (RW+1)'(row_q) + (RW+1)'(1);
	assign drain_nx = (CW+1)'(drain_q) + (CW+1)'(1);

	assign pixel.ready = (state_q == S_IDLE);
	assign pix_acc     = pixel.valid && pixel.ready;

	// read-then-write: one access per cycle per store, no overlap
	always_ff @(posedge clk) begin
		if (mem_we) begin
			older_mem[col_q[AW-1:0]] <= rd_new_q;
			newer_mem[col_q[AW-1:0]] <= px_q;
		end
		if (state_q == S_IDLE || state_q == S_DRA) begin
			rd_old_q <= older_mem[rd_addr];
			rd_new_q <= newer_mem[rd_addr];
		end
	end

	// neighborhood selection with zero padding
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (kind_q == K_LAST) begin
				nb[i][0] = (cur_c_q != '0) ? win_q[i][1] : '0;
				nb[i][1] = win_q[i][2];
				nb[i][2] = '0;
			end else begin
				nb[i][0] = (kind_q == K_INNER && cur_c_q == CW'(1)) ? '0 : win_q[i][0];
				nb[i][1] = win_q[i][1];
				nb[i][2] = win_q[i][2];
			end
		end
		top_zero = (kind_q == K_DRAIN) ? (eff_h < RW'(2)) : (res_row_q == '0);
		if (top_zero) begin
			nb[0][0] = '0;
			nb[0][1] = '0;
			nb[0][2] = '0;
		end
	end

	// per-channel Gx / Gy
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			gx[k] = sobel_pkg::grad_t'(
				  11'(nb[0][2][23-8*k -: 8]) + 11'({nb[1][2][23-8*k -: 8], 1'b0})
				+ 11'(nb[2][2][23-8*k -: 8])
				- 11'(nb[0][0][23-8*k -: 8]) - 11'({nb[1][0][23-8*k -: 8], 1'b0})
				- 11'(nb[2][0][23-8*k -: 8]));
			gy[k] = sobel_pkg::grad_t'(
				  11'(nb[2][0][23-8*k -: 8]) + 11'({nb[2][1][23-8*k -: 8], 1'b0})
				+ 11'(nb[2][2][23-8*k -: 8])
				- 11'(nb[0][0][23-8*k -: 8]) - 11'({nb[0][1][23-8*k -: 8], 1'b0})
				- 11'(nb[0][2][23-8*k -: 8]));
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_mag
		sobel_mag u_mag (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (state_q == S_JOB),
			.gx     (gx[k]),
			.gy     (gy[k]),
			.done   (mag_done[k]),
			.mag    (mag[k])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cfg_w_q      <= 12'd640;
			cfg_h_q      <= 12'd480;
			col_q        <= '0;
			row_q        <= '0;
			drain_q      <= '0;
			draining_q   <= 1'b0;
			k_q          <= '0;
			ok_q         <= 1'b0;
			kind_q       <= K_INNER;
			pend_b_q     <= 1'b0;
			cur_c_q      <= '0;
			res_row_q    <= '0;
			res_col_q    <= '0;
			res_last_q   <= 1'b0;
			result.valid <= 1'b0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) win_q[i][j] <= '0;
		end else if (cfg_we) begin
			// any write restarts the frame
			if (cfg_index == sobel_pkg::CFG_WIDTH) cfg_w_q <= cfg_data;
			else                                   cfg_h_q <= cfg_data;
			col_q      <= '0;
			row_q      <= '0;
			drain_q    <= '0;
			draining_q <= 1'b0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) win_q[i][j] <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (pix_acc) begin
						if (!pixel.command) begin
							px_q <= {pixel.red_in, pixel.green_in, pixel.blue_in};
							if (!draining_q && col_q < eff_w) state_q <= S_PXRD;
						end else if (draining_q && drain_q < eff_w) begin
							k_q     <= '0;
							state_q <= S_DRA;
						end
					end
				end
				S_PXRD: begin
					for (int i = 0; i < 3; i++) begin
						win_q[i][0] <= win_q[i][1];
						win_q[i][1] <= win_q[i][2];
					end
					win_q[0][2] <= rd_old_q;
					win_q[1][2] <= rd_new_q;
					win_q[2][2] <= px_q;
					cur_c_q   <= col_q;
					res_row_q <= row_q - RW'(1);
					res_last_q <= 1'b0;
					if (row_q != '0 && col_q != '0) begin
						kind_q    <= K_INNER;
						res_col_q <= col_q - CW'(1);
						pend_b_q  <= (col_nx == (CW+1)'(eff_w));
						state_q   <= S_JOB;
					end else if (row_q != '0 && col_nx == (CW+1)'(eff_w)) begin
						kind_q    <= K_LAST;
						res_col_q <= col_q;
						pend_b_q  <= 1'b0;
						state_q   <= S_JOB;
					end else begin
						state_q <= S_IDLE;
					end
					// advance raster position
					if (col_nx >= (CW+1)'(eff_w)) begin
						col_q <= '0;
						if (row_nx >= (RW+1)'(eff_h)) begin
							draining_q <= 1'b1;
							drain_q    <= '0;
						end else begin
							row_q <= row_q + RW'(1);
						end
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
				S_DRA: begin
					ok_q    <= cc_ok;
					state_q <= S_DRB;
				end
				S_DRB: begin
					for (int i = 0; i < 3; i++) begin
						win_q[i][0] <= win_q[i][1];
						win_q[i][1] <= win_q[i][2];
					end
					win_q[0][2] <= ok_q ? rd_old_q : '0;
					win_q[1][2] <= ok_q ? rd_new_q : '0;
					win_q[2][2] <= '0;
					if (k_q == 2'd2) begin
						kind_q     <= K_DRAIN;
						res_row_q  <= eff_h - RW'(1);
						res_col_q  <= drain_q;
						res_last_q <= (drain_nx == (CW+1)'(eff_w));
						pend_b_q   <= 1'b0;
						state_q    <= S_JOB;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_DRA;
					end
				end
				S_JOB: state_q <= S_MAG;
				S_MAG: begin
					if (mag_done[0]) begin
						result.red_out       <= mag[0];
						result.green_out     <= mag[1];
						result.blue_out      <= mag[2];
						result.out_row       <= 11'(res_row_q);
						result.out_col       <= 11'(res_col_q);
						result.last_of_frame <= res_last_q;
						result.valid         <= 1'b1;
						state_q              <= S_OUT;
					end
				end
				S_OUT: begin
					if (result.ready) begin
						result.valid <= 1'b0;
						if (pend_b_q) begin
							pend_b_q  <= 1'b0;
							kind_q    <= K_LAST;
							res_col_q <= cur_c_q;
							state_q   <= S_JOB;
						end else begin
							state_q <= S_IDLE;
							if (kind_q == K_DRAIN) begin
								if (drain_nx >= (CW+1)'(eff_w)) begin
									col_q      <= '0;
									row_q      <= '0;
									drain_q    <= '0;
									draining_q <= 1'b0;
									for (int i = 0; i < 3; i++)
										for (int j = 0; j < 3; j++) win_q[i][j] <= '0;
								end else begin
									drain_q <= drain_q + CW'(1);
								end
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// no new request while a result is pending
	a_ready_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.ready |-> !result.valid)
		else $error("request accepted while result pending");

	// root units only finish while the sequencer waits for them
	a_done_in_mag: assert property (@(posedge clk) disable iff (!arst_n)
		mag_done[0] |-> state_q == S_MAG)
		else $error("root unit finished outside wait state");

	// all three channel units run in lockstep
	a_mag_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		mag_done[0] == mag_done[1] && mag_done[1] == mag_done[2])
		else $error("channel root units out of step");

	// once the frame is complete the raster column sits at zero
	a_drain_col_zero: assert property (@(posedge clk) disable iff (!arst_n)
		draining_q |-> col_q == '0)
		else $error("column counter moved while draining");

endmodule

@@ hdl/sobel_mag.sv @@
// ----------------------------------------------------------------------------
// sobel_mag: rounded gradient magnitude
// round(sqrt(gx^2+gy^2)) capped at 255, one result bit per cycle.
// ----------------------------------------------------------------------------
module sobel_mag (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  sobel_pkg::grad_t  gx,
	input  sobel_pkg::grad_t  gy,
	output logic              done,
	output sobel_pkg::mag_t   mag
);

	localparam logic [2:0] P_IDLE = 3'd0;
	localparam logic [2:0] P_SQ   = 3'd1;
	localparam logic [2:0] P_SUM  = 3'd2;
	localparam logic [2:0] P_ITER = 3'd3;
	localparam logic [2:0] P_RND  = 3'd4;

	logic [2:0]                 ph_q;
	sobel_pkg::agrad_t          ax_q, ay_q;
	logic [19:0]                sqx_q, sqy_q;
	logic [20:0]                s_q;
	logic [7:0]                 n_q;
	logic [2:0]                 bit_q;
	logic [7:0]                 trial;
	logic [15:0]                trial_sq;
	logic [16:0]                nn_n;

	assign trial    = n_q | (8'd1 << bit_q);
	assign trial_sq = 16'(trial) * 16'(trial);
	assign nn_n     = 17'(n_q) * 17'(n_q) + 17'(n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= P_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (ph_q)
				P_IDLE: begin
					if (start) ph_q <= P_SQ;
				end
				P_SQ:   ph_q <= P_SUM;
				P_SUM:  ph_q <= P_ITER;
				P_ITER: begin
					if (bit_q == 3'd0) ph_q <= P_RND;
				end
				P_RND: begin
					ph_q <= P_IDLE;
					done <= 1'b1;
				end
				default: ph_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ph_q)
			P_IDLE: begin
				ax_q <= sobel_pkg::abs_grad(gx);
				ay_q <= sobel_pkg::abs_grad(gy);
			end
			P_SQ: begin
				sqx_q <= 20'(ax_q) * 20'(ax_q);
				sqy_q <= 20'(ay_q) * 20'(ay_q);
			end
			P_SUM: begin
				s_q   <= 21'(sqx_q) + 21'(sqy_q);
				n_q   <= 8'd0;
				bit_q <= 3'd7;
			end
			P_ITER: begin
				if (21'(trial_sq) <= s_q) n_q <= trial;
				bit_q <= bit_q - 3'd1;
			end
			P_RND: begin
				if (s_q > sobel_pkg::SQ_LIMIT) mag <= sobel_pkg::MAG_CAP;
				else if (s_q > 21'(nn_n))      mag <= n_q + 8'd1;
				else                           mag <= n_q;
			end
			default: ;
		endcase
	end

endmodule

@@ sim/sobel_edge_magnitude_rgb_tb.sv @@
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_tb: self-checking bench for the RGB Sobel block
// Drives pixel and drain requests across many frame sizes, predicts every
// edge-magnitude result in a scoreboard and checks the results in order.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXW       = 2048;
	localparam int MAXH       = 2048;
	localparam int SETTLE     = 40;    // cycles for a request with no result to finish
	localparam int STALL_MAX  = 3000;  // cycles with no handshake before giving up
	localparam int ITEM_GOAL  = 1900;
	localparam int PHASE_CAP  = 150;   // requests per frame before a size change

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	typedef struct packed {
		sobel_pkg::mag_t             red;
		sobel_pkg::mag_t             green;
		sobel_pkg::mag_t             blue;
		logic [sobel_pkg::POS_W-1:0] row;
		logic [sobel_pkg::POS_W-1:0] col;
		logic                        last;
	} edge_res_t;

	// Frame tracker: mirrors line stores, window and counters, holds the
	// edge results still owed by the block.
	class edge_scoreboard;
		logic [sobel_pkg::CFG_W-1:0] width_reg, height_reg;
		sobel_pkg::pix_t older_line[MAXW];
		sobel_pkg::pix_t newer_line[MAXW];
		sobel_pkg::pix_t win[3][3];
		int        row_pos, col_pos, drain_pos;
		bit        draining, frame_done;
		edge_res_t owed_q[$];
		int        errors, results_seen, frames_done;

		function new();
			width_reg  = 12'd640;
			height_reg = 12'd480;
			foreach (older_line[i]) begin
				older_line[i] = '0;
				newer_line[i] = '0;
			end
			errors = 0;
			results_seen = 0;
			frames_done = 0;
			restart();
		endfunction

		function void restart();
			foreach (win[i, j]) win[i][j] = '0;
			row_pos = 0;
			col_pos = 0;
			drain_pos = 0;
			draining = 0;
		endfunction

		function int clamp_dim(int v, int maxv);
			if (v == 0) return 1;
			return (v > maxv) ? maxv : v;
		endfunction

		function void write_reg(logic idx, logic [sobel_pkg::CFG_W-1:0] value);
			if (idx == sobel_pkg::CFG_WIDTH) width_reg = value;
			else height_reg = value;
			restart();
		endfunction

		function int chan(sobel_pkg::pix_t p, int sh);
			return int'((p >> sh) & 24'hFF);
		endfunction

		// exact rounded root of gx^2 + gy^2, capped
		function sobel_pkg::mag_t magnitude(int gx, int gy);
			int s, n, t;
			s = gx * gx + gy * gy;
			if (s > int'(sobel_pkg::SQ_LIMIT)) return sobel_pkg::MAG_CAP;
			n = 0;
			for (int b = 128; b != 0; b >>= 1) begin
				t = n | b;
				if (t * t <= s) n = t;
			end
			if (s > n * n + n) n++;
			return sobel_pkg::mag_t'(n);
		endfunction

		function edge_res_t sobel_at(sobel_pkg::pix_t nb[3][3], int r, int c, bit last);
			edge_res_t o;
			sobel_pkg::mag_t m[3];
			int sh, gx, gy;
			for (int k = 0; k < 3; k++) begin
				sh = 16 - 8 * k;
				gx = (chan(nb[0][2], sh) + 2 * chan(nb[1][2], sh) + chan(nb[2][2], sh))
					- (chan(nb[0][0], sh) + 2 * chan(nb[1][0], sh) + chan(nb[2][0], sh));
				gy = (chan(nb[2][0], sh) + 2 * chan(nb[2][1], sh) + chan(nb[2][2], sh))
					- (chan(nb[0][0], sh) + 2 * chan(nb[0][1], sh) + chan(nb[0][2], sh));
				m[k] = magnitude(gx, gy);
			end
			o.red   = m[0];
			o.green = m[1];
			o.blue  = m[2];
			o.row   = sobel_pkg::POS_W'(r);
			o.col   = sobel_pkg::POS_W'(c);
			o.last  = last;
			return o;
		endfunction

		// returns the number of results owed, or -1 when the request is ignored
		function int note_request(logic cmd, sobel_pkg::pix_t px);
			int w, h, c, r, d, n;
			sobel_pkg::pix_t nb[3][3];
			w = clamp_dim(width_reg, MAXW);
			h = clamp_dim(height_reg, MAXH);
			n = 0;
			frame_done = 0;
			if (cmd == REQ_PIXEL) begin
				c = col_pos;
				r = row_pos;
				if (draining || c >= w) return -1;
				for (int i = 0; i < 3; i++) begin
					win[i][0] = win[i][1];
					win[i][1] = win[i][2];
				end
				win[0][2] = older_line[c];
				win[1][2] = newer_line[c];
				win[2][2] = px;
				older_line[c] = newer_line[c];
				newer_line[c] = px;
				if (r >= 1) begin
					if (c >= 1) begin
						nb = win;
						if (r == 1) for (int j = 0; j < 3; j++) nb[0][j] = '0;
						if (c == 1) for (int i = 0; i < 3; i++) nb[i][0] = '0;
						owed_q.push_back(sobel_at(nb, r - 1, c - 1, 0));
						n++;
					end
					// last column: right neighbor is outside the frame
					if (c == w - 1) begin
						for (int i = 0; i < 3; i++) begin
							nb[i][0] = (c >= 1) ? win[i][1] : '0;
							nb[i][1] = win[i][2];
							nb[i][2] = '0;
						end
						if (r == 1) for (int j = 0; j < 3; j++) nb[0][j] = '0;
						owed_q.push_back(sobel_at(nb, r - 1, c, 0));
						n++;
					end
				end
				c++;
				if (c >= w) begin
					c = 0;
					if (r + 1 >= h) begin
						draining = 1;
						drain_pos = 0;
					end else begin
						r++;
					end
				end
				col_pos = c;
				row_pos = r;
			end else begin
				d = drain_pos;
				if (!draining || d >= w) return -1;
				for (int j = 0; j < 3; j++) begin
					c = d - 1 + j;
					if (c >= 0 && c < w) begin
						nb[0][j] = (h >= 2) ? older_line[c] : '0;
						nb[1][j] = newer_line[c];
					end else begin
						nb[0][j] = '0;
						nb[1][j] = '0;
					end
					nb[2][j] = '0;
				end
				owed_q.push_back(sobel_at(nb, h - 1, d, d == w - 1));
				n = 1;
				d++;
				if (d >= w) begin
					restart();
					frame_done = 1;
					frames_done++;
				end else begin
					drain_pos = d;
				end
			end
			return n;
		endfunction

		task report(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			errors++;
		endtask

		task check_result(edge_res_t got);
			edge_res_t want;
			results_seen++;
			if (owed_q.size() == 0) begin
				report($sformatf("unexpected result row %0d col %0d", got.row, got.col));
				return;
			end
			want = owed_q.pop_front();
			if (got.red != want.red)
				report($sformatf("red %0d, want %0d at (%0d,%0d)",
					got.red, want.red, want.row, want.col));
			if (got.green != want.green)
				report($sformatf("green %0d, want %0d at (%0d,%0d)",
					got.green, want.green, want.row, want.col));
			if (got.blue != want.blue)
				report($sformatf("blue %0d, want %0d at (%0d,%0d)",
					got.blue, want.blue, want.row, want.col));
			if (got.row != want.row)
				report($sformatf("out_row %0d, want %0d", got.row, want.row));
			if (got.col != want.col)
				report($sformatf("out_col %0d, want %0d", got.col, want.col));
			if (got.last != want.last)
				report($sformatf("last_of_frame %0b, want %0b at (%0d,%0d)",
					got.last, want.last, want.row, want.col));
		endtask
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic                        cfg_index;
	logic [sobel_pkg::CFG_W-1:0] cfg_data;

	sobel_pix_if pix ();
	sobel_res_if res ();

	sobel_edge_magnitude_rgb dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pixel    (pix),
		.result   (res)
	);

	edge_scoreboard sb;
	int             tx_idle_pct;   // sender gap odds, percent
	int             rx_idle_pct;   // receiver stall odds, percent
	int             rx_hold;       // forced receiver hold-off, cycles
	int             live_items;    // requests that were not ignored
	int             idle_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Result side: random back-pressure, plus a long hold-off on request.
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			sb.check_result('{res.red_out, res.green_out, res.blue_out,
				res.out_row, res.out_col, res.last_of_frame});
		if (rx_hold > 0) begin
			res.ready <= 1'b0;
			rx_hold   <= rx_hold - 1;
		end else begin
			res.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Watchdog: bail out if neither channel moves for too long.
	always @(posedge clk) begin
		if ((pix.valid && pix.ready) || (res.valid && res.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_MAX) begin
			$display("timeout: no handshake for %0d cycles", STALL_MAX);
			$display("FAIL");
			$finish;
		end
	end

	// One request: optional random gap, then hold valid until taken.
	// valid is left high afterwards so back-to-back requests stay glued.
	task send_request(logic cmd, sobel_pkg::pix_t px);
		int n;
		while ($urandom_range(99) < tx_idle_pct) begin
			pix.valid <= 1'b0;
			@(posedge clk);
		end
		pix.valid    <= 1'b1;
		pix.command  <= cmd;
		pix.red_in   <= px[23:16];
		pix.green_in <= px[15:8];
		pix.blue_in  <= px[7:0];
		do @(posedge clk); while (!pix.ready);
		n = sb.note_request(cmd, px);
		if (n >= 0) live_items++;
	endtask

	// Sizes change only with nothing in flight.
	task wait_quiet();
		while (sb.owed_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task set_frame(logic [sobel_pkg::CFG_W-1:0] w, logic [sobel_pkg::CFG_W-1:0] h);
		pix.valid <= 1'b0;
		wait_quiet();
		cfg_we    <= 1'b1;
		cfg_index <= sobel_pkg::CFG_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		sb.write_reg(sobel_pkg::CFG_WIDTH, w);
		cfg_index <= sobel_pkg::CFG_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		sb.write_reg(sobel_pkg::CFG_HEIGHT, h);
		cfg_we <= 1'b0;
	endtask

	// channel value leaning toward the rails to reach the cap often
	function logic [7:0] rand_chan();
		if ($urandom_range(3) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
		return 8'($urandom_range(255));
	endfunction

	function sobel_pkg::pix_t rand_pix();
		return {rand_chan(), rand_chan(), rand_chan()};
	endfunction

	initial begin
		logic [sobel_pkg::CFG_W-1:0] w, h;
		logic                        cmd;
		int                          phase, sent;

		sb          = new();
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = sobel_pkg::CFG_WIDTH;
		cfg_data    = '0;
		pix.valid    = 1'b0;
		pix.command  = REQ_PIXEL;
		pix.red_in   = '0;
		pix.green_in = '0;
		pix.blue_in  = '0;
		res.ready   = 1'b0;
		tx_idle_pct = 29;
		rx_idle_pct = 29;
		rx_hold     = 0;
		live_items  = 0;
		idle_cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: 3x3 frame with hard edges. A drain before the frame is
		// complete and a pixel after it are both dropped by the block.
		set_frame(12'd3, 12'd3);
		send_request(REQ_DRAIN, 24'h000000);
		send_request(REQ_PIXEL, 24'hFFFFFF);
		send_request(REQ_PIXEL, 24'h000000);
		send_request(REQ_PIXEL, 24'hFFFFFF);
		send_request(REQ_PIXEL, 24'h000000);
		send_request(REQ_PIXEL, 24'hFF00FF);
		send_request(REQ_PIXEL, 24'h00FF00);
		send_request(REQ_PIXEL, 24'hFFFFFF);
		send_request(REQ_PIXEL, 24'h808080);
		send_request(REQ_PIXEL, 24'h000000);
		send_request(REQ_PIXEL, 24'h123456);  // frame full: dropped
		send_request(REQ_DRAIN, 24'h000000);
		send_request(REQ_DRAIN, 24'h000000);
		send_request(REQ_DRAIN, 24'h000000);
		send_request(REQ_DRAIN, 24'h000000);  // nothing left to drain
		// zero size registers behave as a 1x1 frame
		set_frame(12'd0, 12'd0);
		send_request(REQ_PIXEL, 24'hFFFFFF);
		send_request(REQ_DRAIN, 24'h000000);
		send_request(REQ_DRAIN, 24'h000000);

		// Random frames: mostly tiny complete frames, a few oversized ones that
		// get cut short by the next size change. Phases 4 to 8 run with no idling.
		phase = 0;
		while (live_items < ITEM_GOAL) begin
			case (phase)
				0: begin w = 12'hFFF; h = 12'd2;    end
				1: begin w = 12'd2;   h = 12'hFFF;  end
				2: begin w = 12'd2048; h = 12'd2048; end
				3: begin w = 12'd1;   h = 12'd5;    end
				default: begin
					w = 12'($urandom_range(1, 7));
					h = 12'($urandom_range(1, 6));
					if ($urandom_range(19) == 0) w = 12'($urandom_range(2000, 2100));
					if ($urandom_range(19) == 0) h = 12'($urandom_range(2000, 2100));
					if ($urandom_range(29) == 0) w = 12'd0;
				end
			endcase
			set_frame(w, h);
			if (phase == 4) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else if (phase == 9) begin
				tx_idle_pct = 29;
				rx_idle_pct = 29;
			end
			// long receiver hold-off: the block fills and stops taking requests
			if (phase == 6) rx_hold = 400;
			sent = 0;
			while (sent < PHASE_CAP) begin
				cmd = sb.draining ? REQ_DRAIN : REQ_PIXEL;
				if ($urandom_range(99) < 8) cmd = ~cmd;
				send_request(cmd, rand_pix());
				sent++;
				if (sb.frame_done) break;
			end
			phase++;
		end

		pix.valid <= 1'b0;
		wait_quiet();
		if (sb.owed_q.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.owed_q.size()));
		$display("covered %0d size settings, %0d live requests, %0d results, %0d full frames",
			phase + 2, live_items, sb.results_seen, sb.frames_done);
		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("FAIL");
		end
		$finish;
	end

endmodule
